FILE: src/assert_macros.svh
// assertion helpers for the kmer hash index block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property p must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, p, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (p)) else $error(msg);

// antecedent a implies consequent c in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

FILE: src/khie_pkg.sv
// ----------------------------------------------------------------------------
// khie_pkg
// types and constants shared by the kmer hash index engine
// ----------------------------------------------------------------------------
package khie_pkg;

    localparam int unsigned KEY_W    = 60;
    localparam int unsigned IDX_W    = 16;
    localparam int unsigned OFS_W    = 32;
    localparam int unsigned TBITS_W  = 5;

    localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_LOOKUP = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_RANGE    = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]       action;
        logic [KEY_W-1:0] key;
        logic [IDX_W-1:0] entry_index;
        logic [OFS_W-1:0] offset_value;
    } in_item_t;

    typedef struct packed {
        logic             found;
        logic [OFS_W-1:0] start_offset;
        logic [OFS_W-1:0] end_offset;
        logic [1:0]       status;
    } out_item_t;

endpackage

FILE: src/khie_ram.sv
// ----------------------------------------------------------------------------
// khie_ram
// single-port ram with registered read
// ----------------------------------------------------------------------------
module khie_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: src/khie_front.sv
// ----------------------------------------------------------------------------
// khie_front
// accepts items, hashes the key over a short pipeline, feeds the task queue
// ----------------------------------------------------------------------------
module khie_front
    import khie_pkg::*;
#(
    parameter int unsigned SLOT_BITS = 16,
    parameter int unsigned KEY_BITS  = 60
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  in_item_t             item,
    input  logic [SLOT_BITS-1:0] mask,
    output logic                 q_valid,
    input  logic                 q_ready,
    output in_item_t             q_item,
    output logic [SLOT_BITS-1:0] q_home
);

    localparam int unsigned QD = 2;
    localparam int unsigned NS = 5;

    // hash pipeline: s0 mix1, s1 mul1 partial products, s2 mul1 sum and mix2,
    // s3 mul2 partial products, s4 mul2 sum and final mix
    logic [NS-1:0]        v_reg;
    in_item_t             it_reg [NS];
    logic [63:0]          a_reg;
    logic [63:0]          p1_ll_reg;
    logic [31:0]          p1_x_reg;
    logic [63:0]          b_reg;
    logic [63:0]          p2_ll_reg;
    logic [31:0]          p2_x_reg;
    logic [SLOT_BITS-1:0] home_reg;
    logic [63:0]          p1_ll_next;
    logic [31:0]          p1_x_next;
    logic [63:0]          m1_next;
    logic [63:0]          p2_ll_next;
    logic [31:0]          p2_x_next;
    logic [63:0]          m2_next;
    logic                 advance;
    in_item_t             item_m;

    // queue
    in_item_t             qi_reg [QD];
    logic [SLOT_BITS-1:0] qh_reg [QD];
    logic                 wp_reg;
    logic                 rp_reg;
    logic [1:0]           cnt_reg;
    logic                 q_push;
    logic                 q_pop;
    logic [63:0]          kx;
    logic [63:0]          fin;

    assign kx = 64'(item.key[KEY_BITS-1:0]);

    always_comb
    begin
        item_m     = item;
        item_m.key = KEY_W'(kx);
    end

    assign p1_ll_next = {32'b0, a_reg[31:0]} * {32'b0, MIX_C1[31:0]};
    assign p1_x_next  = a_reg[31:0] * MIX_C1[63:32] + a_reg[63:32] * MIX_C1[31:0];
    assign m1_next    = p1_ll_reg + {p1_x_reg, 32'b0};
    assign p2_ll_next = {32'b0, b_reg[31:0]} * {32'b0, MIX_C2[31:0]};
    assign p2_x_next  = b_reg[31:0] * MIX_C2[63:32] + b_reg[63:32] * MIX_C2[31:0];
    assign m2_next    = p2_ll_reg + {p2_x_reg, 32'b0};
    assign fin        = m2_next ^ (m2_next >> 33);

    // the pipeline holds as a whole when the queue cannot take its last stage
    assign q_push  = v_reg[NS-1] && (cnt_reg != 2'd2);
    assign advance = !v_reg[NS-1] || q_push;
    assign full    = !advance;
    assign q_pop   = q_valid && q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (advance)
        begin
            v_reg <= {v_reg[NS-2:0], push};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            it_reg[0] <= item_m;
            a_reg     <= kx ^ (kx >> 33);
            it_reg[1] <= it_reg[0];
            p1_ll_reg <= p1_ll_next;
            p1_x_reg  <= p1_x_next;
            it_reg[2] <= it_reg[1];
            b_reg     <= m1_next ^ (m1_next >> 33);
            it_reg[3] <= it_reg[2];
            p2_ll_reg <= p2_ll_next;
            p2_x_reg  <= p2_x_next;
            it_reg[4] <= it_reg[3];
            home_reg  <= fin[SLOT_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (q_push)
            begin
                wp_reg <= !wp_reg;
            end
            if (q_pop)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(q_push) - 2'(q_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            qi_reg[wp_reg] <= it_reg[NS-1];
            qh_reg[wp_reg] <= home_reg;
        end
    end

    // mask is applied on the read side; config must only change while idle, unenforced
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = qi_reg[rp_reg];
    assign q_home  = qh_reg[rp_reg] & mask;

endmodule

FILE: src/khie_back.sv
// ----------------------------------------------------------------------------
// khie_back
// probe sequencer over slot and offset memories, with result output register
// ----------------------------------------------------------------------------
module khie_back
    import khie_pkg::*;
#(
    parameter int unsigned SLOT_BITS = 16,
    parameter int unsigned MAX_ROWS  = 32768,
    parameter int unsigned KEY_BITS  = 60
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  in_item_t             q_item,
    input  logic [SLOT_BITS-1:0] q_home,
    input  logic [SLOT_BITS-1:0] mask,
    output logic                 empty,
    input  logic                 pop,
    output out_item_t            result,
    output logic                 busy
);

    localparam int unsigned SLOTS = 1 << SLOT_BITS;
    localparam int unsigned ROW_W = $clog2(MAX_ROWS);
    localparam int unsigned OFS_D = MAX_ROWS + 1;
    localparam int unsigned OA_W  = $clog2(OFS_D);
    localparam int unsigned SLOT_D = (SLOTS + 1);  // probe count width source
    localparam int unsigned CNT_W = $clog2(SLOT_D);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_PROBE, S_CHECK, S_OFS0, S_OFS1, S_OFS2, S_OUT, S_WIPE
    } state_t;

    function automatic out_item_t status_only(status_t st);
        out_item_t r;
        r        = '0;
        r.status = st;
        return r;
    endfunction

    state_t                state_reg;
    in_item_t              it_reg;
    logic [SLOT_BITS-1:0]  slot_reg;
    logic [CNT_W-1:0]      n_reg;
    logic [SLOT_BITS-1:0]  wipe_reg;
    logic [ROW_W-1:0]      row_reg;
    logic [OFS_W-1:0]      start_reg;
    out_item_t             wres_reg;
    out_item_t             res_reg;
    logic                  rv_reg;
    logic                  out_load;
    logic [CNT_W-1:0]      size;

    // slot memory: used | row | key
    localparam int unsigned SW = 1 + ROW_W + KEY_BITS;
    logic                   s_we;
    logic [SLOT_BITS-1:0]   s_addr;
    logic [SW-1:0]          s_wdata;
    logic [SW-1:0]          s_rdata;
    logic                   o_we;
    logic [OA_W-1:0]        o_addr;
    logic [OFS_W-1:0]       o_rdata;

    logic                   r_used;
    logic [ROW_W-1:0]       r_row;
    logic [KEY_BITS-1:0]    r_key;

    assign r_used = s_rdata[SW-1];
    assign r_row  = s_rdata[KEY_BITS +: ROW_W];
    assign r_key  = s_rdata[KEY_BITS-1:0];
    assign size   = CNT_W'({1'b0, mask}) + CNT_W'(1);

    khie_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_slot_ram (
        .clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata)
    );

    khie_ram #(.WIDTH(OFS_W), .DEPTH(OFS_D)) u_ofs_ram (
        .clk(clk), .we(o_we), .addr(o_addr), .wdata(q_item.offset_value),
        .rdata(o_rdata)
    );

    // the output register frees the sequencer while a result waits
    assign out_load = (state_reg == S_OUT) && (!rv_reg || pop);
    assign q_ready  = (state_reg == S_IDLE);
    assign empty    = !rv_reg;
    assign result   = res_reg;
    assign busy     = (state_reg != S_IDLE) || rv_reg;

    logic ins_range;
    logic ofs_range;
    assign ins_range = 32'(q_item.entry_index) >= MAX_ROWS;
    assign ofs_range = 32'(q_item.entry_index) > MAX_ROWS;

    always_comb
    begin
        s_we    = 1'b0;
        s_addr  = slot_reg;
        s_wdata = {1'b1, ROW_W'(it_reg.entry_index), it_reg.key[KEY_BITS-1:0]};
        o_we    = 1'b0;
        o_addr  = OA_W'(row_reg);
        unique case (state_reg)
            S_CLR, S_WIPE:
            begin
                s_we    = 1'b1;
                s_addr  = wipe_reg;
                s_wdata = '0;
            end
            S_IDLE:
            begin
                s_addr = q_home;
                o_addr = OA_W'(q_item.entry_index);
                o_we   = q_valid && q_ready
                         && (q_item.action == ACT_WRITE) && !ofs_range;
            end
            S_CHECK:
            begin
                if (!r_used && (it_reg.action == ACT_INSERT))
                begin
                    s_we = 1'b1;
                end
            end
            S_OFS1:
            begin
                o_addr = OA_W'(row_reg) + OA_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            wipe_reg  <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                rv_reg  <= 1'b1;
                res_reg <= wres_reg;
            end
            else if (rv_reg && pop)
            begin
                rv_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLR, S_WIPE:
                begin
                    wipe_reg <= wipe_reg + 1'b1;
                    if (wipe_reg == SLOT_BITS'(SLOTS - 1))
                    begin
                        state_reg <= (state_reg == S_WIPE) ? S_OUT : S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (q_valid && q_ready)
                    begin
                        it_reg   <= q_item;
                        slot_reg <= q_home;
                        n_reg    <= '0;
                        unique case (action_t'(q_item.action))
                            ACT_INSERT:
                            begin
                                if (ins_range)
                                begin
                                    wres_reg  <= status_only(ST_RANGE);
                                    state_reg <= S_OUT;
                                end
                                else
                                begin
                                    state_reg <= S_CHECK;
                                end
                            end
                            ACT_WRITE:
                            begin
                                wres_reg  <= status_only(ofs_range ? ST_RANGE : ST_DONE);
                                state_reg <= S_OUT;
                            end
                            ACT_LOOKUP:
                            begin
                                state_reg <= S_CHECK;
                            end
                            ACT_CLEAR:
                            begin
                                wres_reg  <= status_only(ST_DONE);
                                wipe_reg  <= '0;
                                state_reg <= S_WIPE;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_PROBE:
                begin
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (it_reg.action == ACT_INSERT)
                    begin
                        if (!r_used)
                        begin
                            wres_reg  <= status_only(ST_DONE);
                            state_reg <= S_OUT;
                        end
                        else if (n_reg + CNT_W'(1) == size)
                        begin
                            wres_reg  <= status_only(ST_FULL);
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            n_reg     <= n_reg + CNT_W'(1);
                            slot_reg  <= (slot_reg + 1'b1) & mask;
                            state_reg <= S_PROBE;
                        end
                    end
                    else
                    begin
                        if (!r_used)
                        begin
                            wres_reg  <= status_only(ST_NOTFOUND);
                            state_reg <= S_OUT;
                        end
                        else if (r_key == it_reg.key[KEY_BITS-1:0])
                        begin
                            row_reg   <= r_row;
                            state_reg <= S_OFS0;
                        end
                        else if (n_reg + CNT_W'(1) == size)
                        begin
                            wres_reg  <= status_only(ST_NOTFOUND);
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            n_reg     <= n_reg + CNT_W'(1);
                            slot_reg  <= (slot_reg + 1'b1) & mask;
                            state_reg <= S_PROBE;
                        end
                    end
                end
                S_OFS0:
                begin
                    state_reg <= S_OFS1;
                end
                S_OFS1:
                begin
                    start_reg <= o_rdata;
                    state_reg <= S_OFS2;
                end
                S_OFS2:
                begin
                    wres_reg  <= {1'b1, start_reg, o_rdata, ST_DONE};
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: src/kmer_hash_index_engine_top.sv
// ----------------------------------------------------------------------------
// kmer_hash_index_engine_top
// open-addressing k-mer index with row offset table
// ----------------------------------------------------------------------------
// input channel: push/full, one item per transfer (insert, offset write,
//   lookup, clear); output channel: empty/pop, one result per item, in order
// cfg_we/cfg_wdata write table_bits, only while the block is idle: a user rule, not enforced
// a front part hashes the key in a five-stage pipeline and queues items in
//   a two-entry queue; the back part walks the slot memory one probe at a time
//   through the slot ram's registered read port
// a lookup hit adds the two offset ram reads and a clear wipes every slot;
//   the back part takes a new item only after the last result has moved
//   into its output register
// after reset the back part sweeps every slot of the slot memory and starts
//   no item until done; config writes are still taken
// when the receiver stalls the result holds, the back part finishes one
//   more item into its work register, the queue and hash pipeline fill,
//   then full rises
// ----------------------------------------------------------------------------
module kmer_hash_index_engine_top
    import khie_pkg::*;
#(
    parameter int unsigned SLOT_BITS = 16,
    parameter int unsigned MAX_ROWS  = 32768,
    parameter int unsigned KEY_BITS  = 60
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  in_item_t           in_item,
    output logic               empty,
    input  logic               pop,
    output out_item_t          out_item,
    input  logic               cfg_we,
    input  logic [TBITS_W-1:0] cfg_wdata
);

`include "assert_macros.svh"

    logic [TBITS_W-1:0]   table_bits_reg;
    logic [TBITS_W-1:0]   act_bits;
    logic [SLOT_BITS-1:0] mask;
    logic                 q_valid;
    logic                 q_ready;
    in_item_t             q_item;
    logic [SLOT_BITS-1:0] q_home;
    logic                 busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_bits_reg <= TBITS_W'(16);
        end
        else if (cfg_we)
        begin
            table_bits_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        act_bits = table_bits_reg;
        if (act_bits == '0)
        begin
            act_bits = TBITS_W'(1);
        end
        if (32'(act_bits) > SLOT_BITS)
        begin
            act_bits = TBITS_W'(SLOT_BITS);
        end
        mask = SLOT_BITS'((33'd1 << act_bits) - 33'd1);
    end

    khie_front #(.SLOT_BITS(SLOT_BITS), .KEY_BITS(KEY_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .item(in_item),
        .mask(mask), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .q_home(q_home)
    );

    khie_back #(.SLOT_BITS(SLOT_BITS), .MAX_ROWS(MAX_ROWS), .KEY_BITS(KEY_BITS))
        u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
        .q_item(q_item), .q_home(q_home), .mask(mask), .empty(empty),
        .pop(pop), .result(out_item), .busy(busy)
    );

    `ASSERT_ALWAYS(a_res_found_done, clk, rst_n,
        empty || !out_item.found || (out_item.status == ST_DONE),
        "found result without done status")
    `ASSERT_ALWAYS(a_res_zero, clk, rst_n,
        empty || out_item.found || (out_item.start_offset == '0),
        "miss result with nonzero offset")
    `ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty,
        "result dropped while stalled")
    `ASSERT_ALWAYS(a_empty_busy, clk, rst_n, empty || busy,
        "result shown while back part reports idle")

endmodule

FILE: verif/tb_kmer_hash_index_engine_top.sv
// ----------------------------------------------------------------------------
// tb_kmer_hash_index_engine_top
// self-checking bench for the kmer hash index engine: a scoreboard class
// mirrors the slot and offset tables, predicts one result per item and checks
// every result popped; directed edge cases, then random phases over several
// table sizes with random idling on both queue sides
// ----------------------------------------------------------------------------
module tb_kmer_hash_index_engine_top;
    import khie_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SLOT_BITS = 16;
    localparam int unsigned MAX_ROWS  = 32768;
    localparam int unsigned KEY_BITS  = 60;

    class result_tracker;
        bit               slot_used [1 << SLOT_BITS];
        logic [KEY_W-1:0] slot_key  [1 << SLOT_BITS];
        logic [IDX_W-1:0] slot_row  [1 << SLOT_BITS];
        logic [OFS_W-1:0] offsets   [MAX_ROWS + 1];
        logic [4:0]       tbits;
        out_item_t        expected_q [$];
        int               fails;

        function new();
            tbits = 5'd16;
            fails = 0;
            foreach (slot_used[i]) slot_used[i] = 1'b0;
        endfunction

        function void set_bits(logic [4:0] b);
            tbits = b;
        endfunction

        function logic [63:0] hash_key(logic [63:0] v);
            v = v ^ (v >> 33);
            v = v * MIX_C1;
            v = v ^ (v >> 33);
            v = v * MIX_C2;
            v = v ^ (v >> 33);
            return v;
        endfunction

        function void note(in_item_t it);
            out_item_t     e;
            int unsigned   b;
            int unsigned   size;
            int unsigned   mask;
            int unsigned   slot;
            int unsigned   row;
            logic [63:0]   h;
            e = '0;
            b = tbits;
            if (b < 1) b = 1;
            if (b > SLOT_BITS) b = SLOT_BITS;
            size = 1 << b;
            mask = size - 1;
            h = hash_key({4'b0, it.key});
            slot = h[31:0] & mask;
            case (it.action)
                ACT_INSERT:
                begin
                    if (it.entry_index >= MAX_ROWS)
                        e.status = ST_RANGE;
                    else
                    begin
                        e.status = ST_FULL;
                        for (int n = 0; n < size; n++)
                        begin
                            if (!slot_used[slot])
                            begin
                                slot_used[slot] = 1'b1;
                                slot_key[slot] = it.key;
                                slot_row[slot] = it.entry_index;
                                e.status = ST_DONE;
                                break;
                            end
                            slot = (slot + 1) & mask;
                        end
                    end
                end
                ACT_WRITE:
                begin
                    if (it.entry_index > MAX_ROWS)
                        e.status = ST_RANGE;
                    else
                        offsets[it.entry_index] = it.offset_value;
                end
                ACT_LOOKUP:
                begin
                    e.status = ST_NOTFOUND;
                    for (int n = 0; n < size; n++)
                    begin
                        if (!slot_used[slot])
                            break;
                        if (slot_key[slot] == it.key)
                        begin
                            row = slot_row[slot];
                            if (row < MAX_ROWS)
                            begin
                                e.found = 1'b1;
                                e.start_offset = offsets[row];
                                e.end_offset = offsets[row + 1];
                                e.status = ST_DONE;
                            end
                            break;
                        end
                        slot = (slot + 1) & mask;
                    end
                end
                default:
                    foreach (slot_used[i]) slot_used[i] = 1'b0;
            endcase
            expected_q = {expected_q, e};
        endfunction

        function void check(out_item_t got);
            out_item_t e;
            if (expected_q.size() == 0)
            begin
                $error("result with no expected transfer");
                fails++;
                return;
            end
            e = expected_q.pop_front();
            if (got.found !== e.found)
            begin
                $error("found: expected %0d actual %0d", e.found, got.found);
                fails++;
            end
            if (got.start_offset !== e.start_offset)
            begin
                $error("start_offset: expected %0h actual %0h", e.start_offset, got.start_offset);
                fails++;
            end
            if (got.end_offset !== e.end_offset)
            begin
                $error("end_offset: expected %0h actual %0h", e.end_offset, got.end_offset);
                fails++;
            end
            if (got.status !== e.status)
            begin
                $error("status: expected %0d actual %0d", e.status, got.status);
                fails++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    in_item_t           in_item;
    logic               empty;
    logic               pop = 1'b0;
    out_item_t          out_item;
    logic               cfg_we;
    logic [TBITS_W-1:0] cfg_wdata;

    result_tracker sb = new();
    bit            quiet;
    bit            row_written [MAX_ROWS + 1];
    int unsigned   good_rows [$];
    logic [KEY_W-1:0] known_keys [$];

    kmer_hash_index_engine_top #(
        .SLOT_BITS (SLOT_BITS),
        .MAX_ROWS  (MAX_ROWS),
        .KEY_BITS  (KEY_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    initial
    begin
        #12_000_000;
        $display("tb_kmer_hash_index_engine_top failed");
        $finish;
    end

    always @(negedge clk)
        pop <= quiet || ($urandom_range(0, 99) >= 9);

    always @(posedge clk)
        if (rst_n && pop && !empty)
            sb.check(out_item);

    function logic [KEY_W-1:0] rand_key();
        return KEY_W'({$urandom, $urandom});
    endfunction

    function void mark_written(int unsigned idx);
        if (idx > MAX_ROWS || row_written[idx])
            return;
        row_written[idx] = 1'b1;
        if (idx > 0 && row_written[idx - 1]) good_rows = {good_rows, idx - 1};
        if (idx < MAX_ROWS && row_written[idx + 1]) good_rows = {good_rows, idx};
    endfunction

    task automatic send(logic [1:0] act, logic [KEY_W-1:0] key,
                        logic [IDX_W-1:0] idx, logic [OFS_W-1:0] val);
        in_item_t it;
        it.action = act;
        it.key = key;
        it.entry_index = idx;
        it.offset_value = val;
        if (act == ACT_WRITE) mark_written(idx);
        if (act == ACT_INSERT && idx < MAX_ROWS) known_keys = {known_keys, key};
        while (!quiet && $urandom_range(0, 99) < 9)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (full);
        sb.note(it);
        @(negedge clk);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_bits(logic [4:0] b);
        cfg_we <= 1'b1;
        cfg_wdata <= b;
        sb.set_bits(b);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_item();
        int unsigned r;
        logic [KEY_W-1:0] k;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            k = (known_keys.size() > 0 && $urandom_range(0, 9) == 0)
                ? known_keys[$urandom_range(0, known_keys.size() - 1)] : rand_key();
            if ($urandom_range(0, 9) == 0)
                send(ACT_INSERT, k, IDX_W'($urandom_range(MAX_ROWS, 65535)), $urandom);
            else
                send(ACT_INSERT, k,
                     IDX_W'(good_rows[$urandom_range(0, good_rows.size() - 1)]),
                     $urandom);
        end
        else if (r < 55)
        begin
            if ($urandom_range(0, 9) == 0)
                send(ACT_WRITE, rand_key(), IDX_W'($urandom_range(MAX_ROWS + 1, 65535)),
                     $urandom);
            else
                send(ACT_WRITE, rand_key(), IDX_W'($urandom_range(0, MAX_ROWS)), $urandom);
        end
        else
        begin
            k = (known_keys.size() > 0 && $urandom_range(0, 9) < 7)
                ? known_keys[$urandom_range(0, known_keys.size() - 1)] : rand_key();
            send(ACT_LOOKUP, k, IDX_W'($urandom), $urandom);
        end
        if (known_keys.size() > 512) void'(known_keys.pop_front());
    endtask

    initial
    begin
        logic [4:0] phase_bits [8];
        logic [KEY_W-1:0] ones;
        phase_bits = '{5'd16, 5'd4, 5'd1, 5'd0, 5'd31, 5'd8, 5'd2, 5'd12};
        ones = '1;
        rst_n = 1'b0;
        push = 1'b0;
        in_item = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        quiet = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed edge cases at the reset table size
        send(ACT_WRITE, '0, 16'd0, 32'h0);
        send(ACT_WRITE, '0, 16'd1, 32'hffffffff);
        send(ACT_WRITE, '0, 16'd2, 32'h12345678);
        send(ACT_WRITE, ones, 16'd32767, 32'ha5a5a5a5);
        send(ACT_WRITE, ones, 16'd32768, 32'h5a5a5a5a);
        send(ACT_WRITE, ones, 16'd32769, 32'hdeadbeef);
        send(ACT_WRITE, ones, 16'hffff, 32'hffffffff);
        send(ACT_INSERT, '0, 16'd0, 32'h0);
        send(ACT_INSERT, ones, 16'd32767, 32'hffffffff);
        send(ACT_INSERT, 60'h123, 16'd32768, 32'h0);
        send(ACT_INSERT, 60'h456, 16'hffff, 32'h0);
        send(ACT_LOOKUP, '0, 16'h0, 32'h0);
        send(ACT_LOOKUP, ones, 16'hffff, 32'hffffffff);
        send(ACT_LOOKUP, 60'h123, 16'h0, 32'h0);
        send(ACT_INSERT, '0, 16'd1, 32'h0);
        send(ACT_LOOKUP, '0, 16'h0, 32'h0);
        drain();

        // two-slot table: fill it, overflow, miss over the whole table, clear
        write_bits(5'd1);
        send(ACT_CLEAR, ones, 16'hffff, 32'hffffffff);
        send(ACT_INSERT, 60'h1, 16'd0, 32'h0);
        send(ACT_INSERT, 60'h2, 16'd1, 32'h0);
        send(ACT_INSERT, 60'h3, 16'd0, 32'h0);
        send(ACT_LOOKUP, 60'h3, 16'h0, 32'h0);
        send(ACT_LOOKUP, 60'h2, 16'h0, 32'h0);
        send(ACT_CLEAR, '0, 16'h0, 32'h0);
        send(ACT_LOOKUP, 60'h1, 16'h0, 32'h0);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            write_bits(phase_bits[p]);
            if (p == 2 || p == 5)
                send(ACT_CLEAR, rand_key(), IDX_W'($urandom), $urandom);
            quiet = (p == 3);
            for (int i = 0; i < 190; i++)
            begin
                if (p == 0 && i == 95) drain();
                random_item();
            end
            quiet = 1'b0;
            drain();
        end

        if (sb.fails == 0)
            $display("tb_kmer_hash_index_engine_top passed");
        else
            $display("tb_kmer_hash_index_engine_top failed");
        $finish;
    end

endmodule
